### rtl/mft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mft_pkg;

    // field widths
    localparam int ANGLE_W    = 13;
    localparam int SAMPLE_W   = 16;
    localparam int TEMP_W     = 8;
    localparam int WORD_W     = 32;
    localparam int WEIGHT_W   = 17;
    localparam int RUN_W      = 12;
    localparam int DELTA_W    = ANGLE_W + 1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_OFFSET      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_SMOOTHING   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_SMOOTHING = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMPERATURE_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_CURRENT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_FRAMES      = 3'd5;

    // reset values of the registers
    localparam logic [ANGLE_W-1:0]  RST_ANGLE_OFFSET = 13'd0;
    localparam logic [WEIGHT_W-1:0] Q16_ONE          = 17'd65536;
    localparam logic [TEMP_W-1:0]   RST_TEMP_LIMIT   = 8'd80;
    localparam logic [SAMPLE_W-1:0] RST_STALL_CUR    = 16'd20000;
    localparam logic [RUN_W-1:0]    RST_STALL_FRAMES = 12'd2000;

    // unwrap constants
    localparam logic signed [DELTA_W-1:0] HALF_TURN     = 14'sd4096;
    localparam logic signed [DELTA_W-1:0] NEG_HALF_TURN = -14'sd4096;
    localparam logic signed [DELTA_W-1:0] FULL_TURN     = -14'sd8192;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 152;

    typedef struct packed {
        logic [ANGLE_W-1:0]         raw_angle;
        logic signed [SAMPLE_W-1:0] raw_speed;
        logic signed [SAMPLE_W-1:0] raw_current;
        logic [TEMP_W-1:0]          temperature;
        logic signed [SAMPLE_W-1:0] drive_current;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]       angle;
        logic signed [WORD_W-1:0] turns;
        logic signed [WORD_W-1:0] total_position;
        logic signed [WORD_W-1:0] speed_smoothed;
        logic signed [WORD_W-1:0] current_smoothed;
        logic [TEMP_W-1:0]        temperature_out;
        logic                     overheat;
        logic                     stalled;
    } result_t;

endpackage

`default_nettype wire

### rtl/mft_unwrap.sv
`timescale 1ns / 1ps
`default_nettype none

module mft_unwrap (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire logic [mft_pkg::ANGLE_W-1:0]          raw_angle,
    input  wire logic [mft_pkg::ANGLE_W-1:0]          angle_offset,
    output logic [mft_pkg::ANGLE_W-1:0]               angle,
    output logic signed [mft_pkg::WORD_W-1:0]         turns_next,
    output logic signed [mft_pkg::WORD_W-1:0]         position_next
);

    logic [mft_pkg::ANGLE_W-1:0]          prev_angle_reg;
    logic signed [mft_pkg::WORD_W-1:0]    turn_count_reg;
    logic signed [mft_pkg::WORD_W-1:0]    position_reg;
    logic signed [mft_pkg::DELTA_W-1:0]   delta;
    logic signed [mft_pkg::DELTA_W-1:0]   delta_adj;

    // offset removal wraps naturally at 13 bits
    assign angle = raw_angle - angle_offset;

    // turn detection at half a turn
    always_comb begin
        delta      = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_reg});
        turns_next = turn_count_reg;
        delta_adj  = delta;
        if (delta > mft_pkg::HALF_TURN) begin
            turns_next = turn_count_reg - 32'sd1;
            delta_adj  = delta + mft_pkg::FULL_TURN;
        end else if (delta < mft_pkg::NEG_HALF_TURN) begin
            turns_next = turn_count_reg + 32'sd1;
            delta_adj  = delta - mft_pkg::FULL_TURN;
        end
        position_next = position_reg
            + {{(mft_pkg::WORD_W-mft_pkg::DELTA_W){delta_adj[mft_pkg::DELTA_W-1]}}, delta_adj};
    end

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            turn_count_reg <= '0;
            position_reg   <= '0;
        end else if (step) begin
            prev_angle_reg <= angle;
            turn_count_reg <= turns_next;
            position_reg   <= position_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mft_smoother.sv
`timescale 1ns / 1ps
`default_nettype none

module mft_smoother (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire logic signed [mft_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [mft_pkg::WEIGHT_W-1:0]         weight,
    output logic signed [mft_pkg::WORD_W-1:0]         filter_next
);

    localparam int DIFF_W = mft_pkg::WORD_W + 1;
    localparam int PROD_W = DIFF_W + mft_pkg::WEIGHT_W + 1;

    logic signed [mft_pkg::WORD_W-1:0]      filter_reg;
    logic [mft_pkg::WEIGHT_W-1:0]           w_sat;
    logic signed [DIFF_W-1:0]               diff;
    logic signed [PROD_W-1:0]               prod;

    // f + floor(w * ((x << 16) - f) / 65536)
    always_comb begin
        w_sat = (weight > mft_pkg::Q16_ONE) ? mft_pkg::Q16_ONE : weight;
        diff  = $signed({sample[mft_pkg::SAMPLE_W-1], sample, 16'd0})
              - $signed({filter_reg[mft_pkg::WORD_W-1], filter_reg});
        prod  = diff * $signed({1'b0, w_sat});
        filter_next = filter_reg + prod[mft_pkg::WORD_W+15:16];
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else if (step) begin
            filter_reg <= filter_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mft_alarm.sv
`timescale 1ns / 1ps
`default_nettype none

module mft_alarm (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire logic [mft_pkg::TEMP_W-1:0]           temperature,
    input  wire logic signed [mft_pkg::SAMPLE_W-1:0]  drive_current,
    input  wire logic [mft_pkg::TEMP_W-1:0]           temperature_limit,
    input  wire logic [mft_pkg::SAMPLE_W-1:0]         stall_current_limit,
    input  wire logic [mft_pkg::RUN_W-1:0]            stall_frame_limit,
    output logic                                      overheat,
    output logic                                      stalled
);

    logic [mft_pkg::RUN_W-1:0]    run_reg;
    logic [mft_pkg::RUN_W-1:0]    run_next;
    logic [mft_pkg::SAMPLE_W-1:0] magnitude;

    // most negative value maps to 32768 in unsigned form
    always_comb begin
        magnitude = drive_current[mft_pkg::SAMPLE_W-1] ? (~drive_current + 16'd1)
                                                       : drive_current;
        if (magnitude >= stall_current_limit) begin
            run_next = (run_reg == mft_pkg::RUN_MAX) ? run_reg : run_reg + 12'd1;
        end else begin
            run_next = '0;
        end
        stalled  = run_next > stall_frame_limit;
        overheat = temperature >= temperature_limit;
    end

    // high-current run counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (step) begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

### rtl/motor_feedback_tracker.sv
// motor_feedback_tracker
// Per-frame motor feedback processing with multi-turn encoder unwrap.
// Input channel s_*: one feedback frame per transfer (angle, speed, current,
// temperature, commanded drive current). Result channel m_*: one result per
// frame with corrected angle, turn count, total position, smoothed speed and
// current in Q16.16, temperature and the overheat and stall flags.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// write only while no frame is in flight.
// Path: a frame accepted into the input register moves to the result register
// when the result slot is free or draining, and m_tvalid follows the result
// register (input register, then result register). Throughput: one frame per
// cycle while results are taken; the turn, filter and run state step per frame.
// Reset (aresetn low, synchronous): tracking state cleared to zero, registers
// back to defaults, both channels empty.
// Stall: while m_tvalid is high and m_tready low the result holds; the input
// register still takes one more frame, then s_tready drops until the result
// is taken.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_tracker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [mft_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // frame input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // raw_angle[12:0], raw_speed[28:13], raw_current[44:29],
    // temperature[52:45], drive_current[68:53], zero fill
    input  wire logic [mft_pkg::S_TDATA_W-1:0]      s_tdata,
    // result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // angle[12:0], turns[44:13], total_position[76:45], speed_smoothed[108:77],
    // current_smoothed[140:109], temperature_out[148:141], overheat[149],
    // stalled[150], zero fill
    output logic [mft_pkg::M_TDATA_W-1:0]           m_tdata
);

    logic [mft_pkg::ANGLE_W-1:0]    angle_offset_reg;
    logic [mft_pkg::WEIGHT_W-1:0]   speed_weight_reg;
    logic [mft_pkg::WEIGHT_W-1:0]   current_weight_reg;
    logic [mft_pkg::TEMP_W-1:0]     temp_limit_reg;
    logic [mft_pkg::SAMPLE_W-1:0]   stall_cur_reg;
    logic [mft_pkg::RUN_W-1:0]      stall_frames_reg;

    logic                           in_valid_reg;
    mft_pkg::in_item_t              in_item_reg;
    logic                           out_valid_reg;
    mft_pkg::result_t               result_reg;
    mft_pkg::result_t               result_next;
    logic                           advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_offset_reg   <= mft_pkg::RST_ANGLE_OFFSET;
            speed_weight_reg   <= mft_pkg::Q16_ONE;
            current_weight_reg <= mft_pkg::Q16_ONE;
            temp_limit_reg     <= mft_pkg::RST_TEMP_LIMIT;
            stall_cur_reg      <= mft_pkg::RST_STALL_CUR;
            stall_frames_reg   <= mft_pkg::RST_STALL_FRAMES;
        end else if (cfg_we) begin
            case (cfg_addr)
                mft_pkg::REG_ANGLE_OFFSET:
                    angle_offset_reg <= cfg_wdata[mft_pkg::ANGLE_W-1:0];
                mft_pkg::REG_SPEED_SMOOTHING:
                    speed_weight_reg <= cfg_wdata[mft_pkg::WEIGHT_W-1:0];
                mft_pkg::REG_CURRENT_SMOOTHING:
                    current_weight_reg <= cfg_wdata[mft_pkg::WEIGHT_W-1:0];
                mft_pkg::REG_TEMPERATURE_LIMIT:
                    temp_limit_reg <= cfg_wdata[mft_pkg::TEMP_W-1:0];
                mft_pkg::REG_STALL_CURRENT:
                    stall_cur_reg <= cfg_wdata[mft_pkg::SAMPLE_W-1:0];
                mft_pkg::REG_STALL_FRAMES:
                    stall_frames_reg <= cfg_wdata[mft_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the frame moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.raw_angle     <= s_tdata[12:0];
            in_item_reg.raw_speed     <= s_tdata[28:13];
            in_item_reg.raw_current   <= s_tdata[44:29];
            in_item_reg.temperature   <= s_tdata[52:45];
            in_item_reg.drive_current <= s_tdata[68:53];
        end
    end

    // processing units
    mft_unwrap u_unwrap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .raw_angle     (in_item_reg.raw_angle),
        .angle_offset  (angle_offset_reg),
        .angle         (result_next.angle),
        .turns_next    (result_next.turns),
        .position_next (result_next.total_position)
    );

    mft_smoother u_speed_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .sample      (in_item_reg.raw_speed),
        .weight      (speed_weight_reg),
        .filter_next (result_next.speed_smoothed)
    );

    mft_smoother u_current_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .sample      (in_item_reg.raw_current),
        .weight      (current_weight_reg),
        .filter_next (result_next.current_smoothed)
    );

    mft_alarm u_alarm (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step                (advance),
        .temperature         (in_item_reg.temperature),
        .drive_current       (in_item_reg.drive_current),
        .temperature_limit   (temp_limit_reg),
        .stall_current_limit (stall_cur_reg),
        .stall_frame_limit   (stall_frames_reg),
        .overheat            (result_next.overheat),
        .stalled             (result_next.stalled)
    );

    assign result_next.temperature_out = in_item_reg.temperature;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = {1'b0,
                      result_reg.stalled,
                      result_reg.overheat,
                      result_reg.temperature_out,
                      result_reg.current_smoothed,
                      result_reg.speed_smoothed,
                      result_reg.total_position,
                      result_reg.turns,
                      result_reg.angle};

endmodule

`default_nettype wire
